[hw/rtl/srx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_pkg
// shared types, constants and the salsa20 round function for the romix core
// ----------------------------------------------------------------------------
package srx_pkg;

    localparam int SRX_COST_N      = 1024;
    localparam int SRX_BLOCK_WORDS = 32;
    localparam int SRX_HALF_WORDS  = 16;

    typedef logic [31:0] word_t;
    typedef word_t [SRX_HALF_WORDS-1:0] half_t;

    // quarter-round word indices: [row round][quarter][a, b, c, d]
    localparam logic [3:0] QIDX [2][4][4] = '{
        '{ '{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
           '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11} },
        '{ '{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
           '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14} }
    };

    function automatic word_t rol32(word_t v, int c);
        return (v << c) | (v >> (32 - c));
    endfunction

    // one salsa20 round, column or row, four independent quarter-rounds
    function automatic half_t salsa_round(half_t s, logic row_rnd);
        half_t      x;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] c;
        logic [3:0] d;
        x = s;
        for (int q = 0; q < 4; q++) begin
            a = QIDX[row_rnd][q][0];
            b = QIDX[row_rnd][q][1];
            c = QIDX[row_rnd][q][2];
            d = QIDX[row_rnd][q][3];
            x[b] = x[b] ^ rol32(x[a] + x[d], 7);
            x[c] = x[c] ^ rol32(x[b] + x[a], 9);
            x[d] = x[d] ^ rol32(x[c] + x[b], 13);
            x[a] = x[a] ^ rol32(x[d] + x[c], 18);
        end
        return x;
    endfunction

endpackage

[hw/rtl/scrypt_romix_core_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrypt_romix_core_top
// scrypt romix (r = 1) over a 32-word block, one salsa20 round per cycle
// ----------------------------------------------------------------------------
// sequence: 32 input transfers, then COST_N block mixes in each of the two phases, then 32 output transfers
// per first-phase block: store, setup, then for each half the rounds of salsa20/8 and a feed-forward
// per second-phase block: index reduction (4 byte steps, quotient then remainder), read, xor, then the mix
// the single salsa round unit is shared by all mixing; one block is handled at a time
// reset: asynchronous active low; returns to loading with the word count at zero
module scrypt_romix_core_top #(
    parameter int COST_N = srx_pkg::SRX_COST_N
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  srx_pkg::word_t      in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output srx_pkg::word_t      out_word,
    output logic                out_last
);
    import srx_pkg::*;

    localparam int AW     = $clog2(COST_N);
    localparam int ROW_W  = 32 * SRX_BLOCK_WORDS;
    localparam int NUM_W  = AW + 8;
    localparam int RCP_W  = AW + 10;
    localparam int RCP_SH = 2 * AW + 8;
    localparam int PROD_W = NUM_W + RCP_W;
    localparam int N1_W   = AW + 1;
    localparam int SUB_W  = N1_W + 8;
    localparam logic [AW-1:0]    LAST_IDX = AW'(COST_N - 1);
    localparam logic [N1_W-1:0]  N_R      = N1_W'(COST_N);
    localparam logic [63:0]      RCP_FULL = ((64'd1 << RCP_SH) / 64'(COST_N)) + 64'd1;
    localparam logic [RCP_W-1:0] RCP      = RCP_FULL[RCP_W-1:0];

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_STORE = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_ROUND = 4'd3;
    localparam logic [3:0] S_FINAL = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_READ  = 4'd6;
    localparam logic [3:0] S_XOR   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic             phase_reg, phase_next;
    logic             half_reg, half_next;
    logic [2:0]       rnd_reg, rnd_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    rem_reg, rem_next;
    logic [7:0]       q_reg, q_next;
    logic [7:0]       mod_byte;
    logic [NUM_W-1:0] mod_num;
    logic [PROD_W-1:0] mod_prod;
    logic [SUB_W-1:0] mod_sub;
    logic [SUB_W-1:0] mod_diff;

    half_t lo_reg, lo_next;
    half_t hi_reg, hi_next;
    half_t t_reg, t_next;
    half_t s_reg, s_next;
    half_t sum;
    half_t rnd_out;

    logic [ROW_W-1:0] scratch_mem [COST_N];
    logic [ROW_W-1:0] rd_reg;
    logic             mem_we;

    // shared round unit and feed-forward adders
    assign rnd_out = salsa_round(s_reg, rnd_reg[0]);
    always_comb
    begin
        for (int j = 0; j < SRX_HALF_WORDS; j++)
        begin
            sum[j] = t_reg[j] + s_reg[j];
        end
    end

    // word 16 modulo the cost, a byte at a time, most significant first
    always_comb
    begin
        case (cnt_reg[2:1])
            2'd0:    mod_byte = hi_reg[0][31:24];
            2'd1:    mod_byte = hi_reg[0][23:16];
            2'd2:    mod_byte = hi_reg[0][15:8];
            default: mod_byte = hi_reg[0][7:0];
        endcase
    end

    // quotient by reciprocal multiply, then remainder by multiply and subtract
    assign mod_num  = {rem_reg, mod_byte};
    assign mod_prod = PROD_W'(mod_num) * PROD_W'(RCP);
    assign mod_sub  = SUB_W'(q_reg) * SUB_W'(N_R);
    assign mod_diff = SUB_W'(mod_num) - mod_sub;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        half_next  = half_reg;
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        t_next     = t_reg;
        s_next     = s_reg;
        mem_we     = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg[4])
                        hi_next[cnt_reg[3:0]] = in_word;
                    else
                        lo_next[cnt_reg[3:0]] = in_word;
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_next = S_STORE;
                        phase_next = 1'b0;
                        idx_next   = '0;
                    end
                end
            end
            S_STORE:
            begin
                mem_we     = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                for (int j = 0; j < SRX_HALF_WORDS; j++)
                begin
                    t_next[j] = lo_reg[j] ^ hi_reg[j];
                end
                s_next     = t_next;
                half_next  = 1'b0;
                rnd_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                s_next   = rnd_out;
                rnd_next = rnd_reg + 3'd1;
                if (rnd_reg == 3'd7)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (!half_reg)
                begin
                    lo_next = sum;
                    for (int j = 0; j < SRX_HALF_WORDS; j++)
                    begin
                        t_next[j] = sum[j] ^ hi_reg[j];
                    end
                    s_next     = t_next;
                    half_next  = 1'b1;
                    state_next = S_ROUND;
                end
                else
                begin
                    hi_next  = sum;
                    rem_next = '0;
                    cnt_next = '0;
                    if (idx_reg == LAST_IDX)
                    begin
                        idx_next = '0;
                        if (phase_reg)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                            state_next = S_MOD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = phase_reg ? S_MOD : S_STORE;
                    end
                end
            end
            S_MOD:
            begin
                if (!cnt_reg[0])
                    q_next = mod_prod[RCP_SH +: 8];
                else
                    rem_next = mod_diff[AW-1:0];
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd7)
                    state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_XOR;
            end
            S_XOR:
            begin
                lo_next    = lo_reg ^ rd_reg[ROW_W/2-1:0];
                hi_next    = hi_reg ^ rd_reg[ROW_W-1:ROW_W/2];
                state_next = S_INIT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    cnt_next = cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                        state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            phase_reg <= 1'b0;
            half_reg  <= 1'b0;
            rnd_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            half_reg  <= half_next;
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    // block and salsa working registers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        t_reg   <= t_next;
        s_reg   <= s_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    // scratch memory, one block per row, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            scratch_mem[idx_reg] <= {hi_reg, lo_reg};
        rd_reg <= scratch_mem[rem_reg];
    end

    // ports
    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign out_word  = cnt_reg[4] ? hi_reg[cnt_reg[3:0]] : lo_reg[cnt_reg[3:0]];
    assign out_last  = (cnt_reg == 5'd31);

endmodule

[hw/rtl/srx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srx_checker
// port-level checks on the romix core, bound to the top level
// ----------------------------------------------------------------------------
module srx_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input srx_pkg::word_t      in_word,
    input logic                out_valid,
    input logic                out_ready,
    input srx_pkg::word_t      out_word,
    input logic                out_last
);
    import srx_pkg::*;

    // never loading and delivering at once
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open together");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
        else $error("stalled result changed");

    // the final word returns the block to loading
    a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> in_ready && !out_valid)
        else $error("no return to loading after last word");

    // an input transfer is never followed at once by a result
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result right after input transfer");

endmodule

bind scrypt_romix_core_top srx_checker u_srx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .out_last  (out_last)
);

[test/scrypt_romix_core_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrypt_romix_core_top_tb
// randomised block test of the romix core against a behavioural predictor
// ----------------------------------------------------------------------------
// 32-word blocks go in with bursty input traffic and a stalling output side.
// A scoreboard mixes each block itself and checks every output transfer in order.
// One long output hold-off fills the core, and one pause drains it completely.
module scrypt_romix_core_top_tb;

    localparam int COST      = srx_pkg::SRX_COST_N;
    localparam int N_BLOCKS  = 12;
    localparam int HOLD_LEN  = 90000;
    localparam int CYC_LIMIT = 4000000;

    typedef bit [31:0] salsa_state_t [16];
    typedef bit [31:0] romix_block_t [32];

    // ------------------------------------------------------------------------
    // scoreboard: romix predictor and queue of pending result words
    // ------------------------------------------------------------------------
    class romix_scoreboard;
        romix_block_t blk;
        bit [31:0]    scratch [];
        int unsigned  word_cnt;
        bit [31:0]    pend_word [$];
        bit           pend_last [$];
        int           errors;

        function new();
            scratch  = new[32 * COST];
            word_cnt = 0;
            errors   = 0;
            foreach (blk[i]) blk[i] = '0;
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int c);
            return (v << c) | (v >> (32 - c));
        endfunction

        function void quarter_rnd(ref salsa_state_t s, input int a, int b, int c, int d);
            s[b] ^= rotl(s[a] + s[d], 7);
            s[c] ^= rotl(s[b] + s[a], 9);
            s[d] ^= rotl(s[c] + s[b], 13);
            s[a] ^= rotl(s[d] + s[c], 18);
        endfunction

        // salsa20/8 with feed-forward
        function salsa_state_t salsa8(salsa_state_t b);
            salsa_state_t s;
            s = b;
            for (int r = 0; r < 4; r++)
            begin
                quarter_rnd(s, 0, 4, 8, 12);
                quarter_rnd(s, 5, 9, 13, 1);
                quarter_rnd(s, 10, 14, 2, 6);
                quarter_rnd(s, 15, 3, 7, 11);
                quarter_rnd(s, 0, 1, 2, 3);
                quarter_rnd(s, 5, 6, 7, 4);
                quarter_rnd(s, 10, 11, 8, 9);
                quarter_rnd(s, 15, 12, 13, 14);
            end
            foreach (s[i]) s[i] = b[i] + s[i];
            return s;
        endfunction

        function void block_mix();
            salsa_state_t t;
            romix_block_t res;
            for (int j = 0; j < 16; j++) t[j] = blk[16 + j] ^ blk[j];
            t = salsa8(t);
            for (int j = 0; j < 16; j++) res[j] = t[j];
            for (int j = 0; j < 16; j++) t[j] ^= blk[16 + j];
            t = salsa8(t);
            for (int j = 0; j < 16; j++) res[16 + j] = t[j];
            blk = res;
        endfunction

        function void romix();
            int unsigned sel;
            for (int i = 0; i < COST; i++)
            begin
                for (int k = 0; k < 32; k++) scratch[i * 32 + k] = blk[k];
                block_mix();
            end
            for (int i = 0; i < COST; i++)
            begin
                sel = blk[16] % COST;
                for (int k = 0; k < 32; k++) blk[k] ^= scratch[sel * 32 + k];
                block_mix();
            end
        endfunction

        // accepted input word; a full block yields 32 expected words
        function void note_input(bit [31:0] w);
            blk[word_cnt] = w;
            word_cnt = (word_cnt + 1) % 32;
            if (word_cnt == 0)
            begin
                romix();
                for (int k = 0; k < 32; k++)
                begin
                    pend_word = {pend_word, blk[k]};
                    pend_last = {pend_last, bit'(k == 31)};
                end
            end
        endfunction

        function void check_result(bit [31:0] w, bit last);
            bit [31:0] ew;
            bit        el;
            if (pend_word.size() == 0)
            begin
                $error("unexpected output transfer: out_word %h out_last %0b", w, last);
                errors++;
                return;
            end
            ew = pend_word.pop_front();
            el = pend_last.pop_front();
            if (ew !== w)
            begin
                $error("out_word mismatch: expected %h, actual %h", ew, w);
                errors++;
            end
            if (el !== last)
            begin
                $error("out_last mismatch: expected %0b, actual %0b", el, last);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    srx_pkg::word_t in_word;
    logic           out_valid;
    logic           out_ready;
    srx_pkg::word_t out_word;
    logic           out_last;

    romix_scoreboard sb;
    int unsigned     cyc = 0;
    bit              hold_req;
    int unsigned     burst_left;

    scrypt_romix_core_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .out_last  (out_last)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_word, out_last);
    end

    // receiver stall pattern, with one long hold-off on request
    initial
    begin
        int unsigned mode;
        int unsigned run;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(1, 40);
            repeat (run)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // one input transfer, bursts separated by random gaps
    task automatic send_word(input bit [31:0] w);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        sb.note_input(w);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // random word: plain, walking bit, or extreme
    function automatic bit [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h1 << $urandom_range(0, 31);
            1: return ~(32'h1 << $urandom_range(0, 31));
            2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        bit [31:0] w;
        sb         = new();
        hold_req   = 1'b0;
        burst_left = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed block: extreme words, word 16 at the top of the index range
        for (int i = 0; i < 32; i++)
        begin
            case (i % 4)
                0: w = 32'h0;
                1: w = 32'hFFFF_FFFF;
                2: w = 32'h8000_0000;
                default: w = 32'h0000_0001;
            endcase
            if (i == 16) w = COST - 1;
            send_word(w);
        end

        // random blocks
        for (int b = 1; b < N_BLOCKS; b++)
        begin
            // long output hold-off while the sender keeps offering words
            if (b == 3) hold_req = 1'b1;
            // drain completely before this block
            if (b == 7)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.pend_word.size() != 0) @(posedge clk);
            end
            for (int i = 0; i < 32; i++) send_word(rand_word());
        end
        idle_input();

        // wait for the last results, then a short settle
        while (sb.pend_word.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
